FILE: hw/rtl/oks_pkg.sv
// ----------------------------------------------------------------------------
// Ordered key set package
// Shared widths, operation codes, state encoding and cell control type.
// ----------------------------------------------------------------------------
package oks_pkg;

    localparam int KEY_W            = 32;
    localparam int KIND_W           = 3;
    localparam int DEFAULT_CAPACITY = 64;
    localparam int IN_DATA_W        = 32;
    localparam int OUT_DATA_W       = 40;

    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EXISTS = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NEXT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PREV   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    typedef struct packed {
        logic cmp_en;
        logic shift_ins;
        logic shift_del;
    } cell_ctrl_t;

endpackage

FILE: hw/rtl/ordered_key_set.sv
// ----------------------------------------------------------------------------
// Ordered key set
// Sorted set of distinct signed keys with insert, delete, membership,
// successor and predecessor queries.
// ----------------------------------------------------------------------------
// The keys sit in a row of CAPACITY cells in ascending order. A request is
// captured, then every cell compares its key with the request key, then the
// row shifts for an insert or delete and the neighbor key is selected into
// the output register; this last step waits while an older result is untaken,
// and only then is the next request accepted. The result is held in that
// register until taken; a new request is accepted while it waits. An insert
// into a full row is dropped and reported with the overflow flag.
module ordered_key_set
    import oks_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // key[31:0]
    input  logic [KIND_W-1:0]     s_tuser,   // kind[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // found[0], answer_key[32:1], overflow[33]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t                  state_reg;
    state_t                  state_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [KIND_W-1:0]       kind_reg;
    logic signed [KEY_W-1:0] req_key_reg;
    logic                    out_valid_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;

    logic signed [KEY_W-1:0] key_arr [CAPACITY];
    logic [CAPACITY-1:0]     lt_vec;
    logic [CAPACITY-1:0]     eq_vec;
    logic [CAPACITY-1:0]     gt_vec;
    logic [CAPACITY-1:0]     occ_vec;

    cell_ctrl_t              ctrl;
    logic                    commit;
    logic                    hit;
    logic                    full;
    logic                    do_ins;
    logic                    do_del;
    logic signed [KEY_W-1:0] next_key;
    logic signed [KEY_W-1:0] prev_key;
    logic                    res_found;
    logic signed [KEY_W-1:0] res_answer;
    logic                    res_overflow;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign commit = (state_reg == ST_UPD) && (!out_valid_reg || m_tready);
    assign hit    = |eq_vec;
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign do_ins = commit && (kind_reg == KIND_INSERT) && !hit && !full;
    assign do_del = commit && (kind_reg == KIND_DELETE) && hit;

    assign ctrl.cmp_en    = (state_reg == ST_CMP);
    assign ctrl.shift_ins = do_ins;
    assign ctrl.shift_del = do_del;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [KEY_W-1:0] left_key;
            logic signed [KEY_W-1:0] right_key;
            logic                    left_lt;

            assign occ_vec[gi] = (count_reg > CNT_W'(gi));

            if (gi == 0)
            begin : g_first
                assign left_key = req_key_reg;
                assign left_lt  = 1'b1;
            end
            else
            begin : g_inner
                assign left_key = key_arr[gi-1];
                assign left_lt  = lt_vec[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_key = key_arr[gi];
            end
            else
            begin : g_body
                assign right_key = key_arr[gi+1];
            end

            oks_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occ       (occ_vec[gi]),
                .req_key   (req_key_reg),
                .left_key  (left_key),
                .right_key (right_key),
                .left_lt   (left_lt),
                .key_reg   (key_arr[gi]),
                .lt_reg    (lt_vec[gi]),
                .eq_reg    (eq_vec[gi]),
                .gt_reg    (gt_vec[gi])
            );
        end
    endgenerate

    // The successor is the first cell above the key; the predecessor is the
    // last cell below it. Both selects are one-hot over the row.
    always_comb
    begin
        next_key = '0;
        prev_key = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (gt_vec[i] && (i == 0 || !gt_vec[(i == 0) ? 0 : i - 1]))
            begin
                next_key = next_key | key_arr[i];
            end
            if (lt_vec[i] && (i == CAPACITY - 1 || !lt_vec[(i == CAPACITY - 1) ? i : i + 1]))
            begin
                prev_key = prev_key | key_arr[i];
            end
        end
    end

    always_comb
    begin
        res_found    = 1'b0;
        res_answer   = '0;
        res_overflow = 1'b0;
        case (kind_reg)
            KIND_INSERT:
            begin
                res_found    = !hit && !full;
                res_overflow = !hit && full;
            end
            KIND_DELETE:
            begin
                res_found = hit;
            end
            KIND_EXISTS:
            begin
                res_found = hit;
            end
            KIND_NEXT:
            begin
                res_found  = |gt_vec;
                res_answer = next_key;
            end
            KIND_PREV:
            begin
                res_found  = |lt_vec;
                res_answer = prev_key;
            end
            default:
            begin
                res_found = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
                if (do_ins)
                begin
                    count_next = count_reg + 1'b1;
                end
                else if (do_del)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            kind_reg    <= s_tuser;
            req_key_reg <= $signed(s_tdata);
        end
        if (commit)
        begin
            out_data_reg <= {6'b0, res_overflow, res_answer, res_found};
        end
    end

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while a request was in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(count_reg))
        else $error("entry count changed outside an update");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> !(res_found && res_overflow))
        else $error("found and overflow both set");

    a_no_shift_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(do_ins && do_del))
        else $error("insert and delete shift at once");

endmodule

FILE: hw/rtl/oks_cell.sv
// ----------------------------------------------------------------------------
// Ordered key set cell
// Holds one key of the sorted row, compares it against the request key and
// shifts toward or away from its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module oks_cell
    import oks_pkg::*;
(
    input  logic                    clk,
    input  cell_ctrl_t              ctrl,
    input  logic                    occ,
    input  logic signed [KEY_W-1:0] req_key,
    input  logic signed [KEY_W-1:0] left_key,
    input  logic signed [KEY_W-1:0] right_key,
    input  logic                    left_lt,
    output logic signed [KEY_W-1:0] key_reg,
    output logic                    lt_reg,
    output logic                    eq_reg,
    output logic                    gt_reg
);

    logic signed [KEY_W-1:0] key_next;
    logic                    lt_next;
    logic                    eq_next;
    logic                    gt_next;

    always_comb
    begin
        lt_next = occ && (key_reg < req_key);
        eq_next = occ && (key_reg == req_key);
        gt_next = occ && (key_reg > req_key);
        key_next = key_reg;
        if (ctrl.shift_ins && !lt_reg)
        begin
            key_next = left_lt ? req_key : left_key;
        end
        else if (ctrl.shift_del && !lt_reg)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (ctrl.cmp_en)
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
            gt_reg <= gt_next;
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered key set testbench
// The testbench drives insert, delete, exists, next, prev and unused-kind
// requests into the key set and keeps its own sorted copy of the set to
// predict each result. The requests are a directed set of corner cases, a
// fill to capacity with overflow, and random phases that alternately grow
// and shrink the set. Both stream sides idle and stall at random, and every
// result is checked in order against the prediction.
// ----------------------------------------------------------------------------
module tb;
    import oks_pkg::*;

    localparam int SET_CAPACITY = DEFAULT_CAPACITY;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_LEN    = 150;
    localparam int POOL_SIZE    = 100;

    localparam logic [KIND_W-1:0]  KIND_FIRST_UNUSED = 3'd5;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic        found;
        logic [31:0] answer_key;
        logic        overflow;
    } set_result_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_RARELY
    } ready_mode_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [KIND_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int          stored_keys[$];
    set_result_t pending_results[$];
    set_result_t head_result;
    int          key_pool[$];

    int          mismatch_count = 0;
    int          result_count   = 0;
    int          cycle_count    = 0;
    int          overflow_count = 0;
    int          peak_fill      = 0;
    int          kind_count[8];
    int          burst_left     = 0;
    int          ready_left     = 0;
    ready_mode_t ready_mode     = READY_ALWAYS;

    ordered_key_set #(
        .CAPACITY (SET_CAPACITY)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic set_result_t predict_set_op(logic [KIND_W-1:0] kind, int key);
        set_result_t res;
        int          pos;
        logic        hit;
        res = '{1'b0, 32'd0, 1'b0};
        pos = 0;
        while (pos < stored_keys.size() && stored_keys[pos] < key)
            pos++;
        hit = (pos < stored_keys.size()) && (stored_keys[pos] == key);
        case (kind)
            KIND_INSERT:
            begin
                if (!hit && stored_keys.size() >= SET_CAPACITY)
                    res.overflow = 1'b1;
                else if (!hit)
                begin
                    stored_keys.insert(pos, key);
                    res.found = 1'b1;
                end
            end
            KIND_DELETE:
            begin
                if (hit)
                begin
                    stored_keys.delete(pos);
                    res.found = 1'b1;
                end
            end
            KIND_EXISTS:
                res.found = hit;
            KIND_NEXT:
            begin
                if (hit)
                    pos++;
                if (pos < stored_keys.size())
                begin
                    res.found      = 1'b1;
                    res.answer_key = stored_keys[pos];
                end
            end
            KIND_PREV:
            begin
                if (pos > 0)
                begin
                    res.found      = 1'b1;
                    res.answer_key = stored_keys[pos - 1];
                end
            end
            default:
                ;
        endcase
        return res;
    endfunction

    function automatic logic is_stored(int key);
        foreach (stored_keys[i])
            if (stored_keys[i] == key)
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic send_request(input logic [KIND_W-1:0] kind, input int key);
        int          gap;
        set_result_t res;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        res = predict_set_op(kind, key);
        pending_results.push_back(res);
        kind_count[kind]++;
        if (res.overflow)
            overflow_count++;
        if (stored_keys.size() > peak_fill)
            peak_fill = stored_keys.size();
    endtask

    task automatic wait_until_idle();
        s_tvalid   <= 1'b0;
        burst_left  = 0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic test_directed();
        send_request(KIND_NEXT, 0);
        send_request(KIND_PREV, 0);
        send_request(KIND_EXISTS, 0);
        send_request(KIND_DELETE, 5);
        send_request(KIND_INSERT, KEY_MIN);
        send_request(KIND_INSERT, KEY_MAX);
        send_request(KIND_INSERT, 0);
        send_request(KIND_INSERT, -1);
        send_request(KIND_INSERT, 1);
        send_request(KIND_INSERT, 0);
        send_request(KIND_EXISTS, KEY_MAX);
        send_request(KIND_NEXT, KEY_MAX);
        send_request(KIND_PREV, KEY_MIN);
        send_request(KIND_NEXT, KEY_MIN);
        send_request(KIND_PREV, KEY_MAX);
        send_request(KIND_NEXT, -1);
        send_request(KIND_PREV, 2);
        send_request(KIND_DELETE, 0);
        send_request(KIND_DELETE, 0);
        send_request(KIND_EXISTS, 0);
        for (int i = 0; i < 3; i++)
            send_request(KIND_W'(KIND_FIRST_UNUSED + i), -1);
        send_request(KIND_DELETE, KEY_MIN);
        send_request(KIND_DELETE, KEY_MAX);
        send_request(KIND_DELETE, -1);
        send_request(KIND_DELETE, 1);
    endtask

    task automatic test_fill_and_overflow();
        int absent_key;
        int idx;
        wait_until_idle();
        while (stored_keys.size() < SET_CAPACITY)
            send_request(KIND_INSERT, $urandom);
        // Hold off until the full set has settled before probing the limit.
        wait_until_idle();
        do absent_key = $urandom; while (is_stored(absent_key));
        send_request(KIND_INSERT, absent_key);
        send_request(KIND_INSERT, stored_keys[$urandom_range(0, SET_CAPACITY - 1)]);
        send_request(KIND_EXISTS, absent_key);
        send_request(KIND_NEXT, stored_keys[SET_CAPACITY - 1]);
        send_request(KIND_PREV, stored_keys[0]);
        send_request(KIND_NEXT, $urandom);
        send_request(KIND_PREV, $urandom);
        send_request(KIND_DELETE, stored_keys[$urandom_range(0, SET_CAPACITY - 1)]);
        send_request(KIND_INSERT, absent_key);
        do absent_key = $urandom; while (is_stored(absent_key));
        send_request(KIND_INSERT, absent_key);
        while (stored_keys.size() > 0)
        begin
            idx = $urandom_range(0, stored_keys.size() - 1);
            if ($urandom_range(0, 3) == 0)
                send_request(KIND_W'(KIND_NEXT + $urandom_range(0, 1)), stored_keys[idx]);
            else
                send_request(KIND_DELETE, stored_keys[idx]);
        end
    endtask

    function automatic int pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (r < 88)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)] + ($urandom_range(0, 1) ? 1 : -1);
        return $urandom;
    endfunction

    task automatic test_random_mix();
        int base;
        int r;
        logic [KIND_W-1:0] kind;
        key_pool = '{KEY_MIN, KEY_MAX, -1, 0, 1};
        while (key_pool.size() < POOL_SIZE)
        begin
            base = $urandom;
            for (int i = 0; i < 5 && key_pool.size() < POOL_SIZE; i++)
                key_pool.push_back(base + $urandom_range(0, 40));
        end
        for (int phase = 0; phase < 6; phase++)
        begin
            for (int i = 0; i < PHASE_LEN; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    kind = KIND_W'(KIND_FIRST_UNUSED + $urandom_range(0, 2));
                else if (r < 48)
                    kind = (phase % 2 == 0) ? KIND_INSERT : KIND_DELETE;
                else if (r < 63)
                    kind = (phase % 2 == 0) ? KIND_DELETE : KIND_INSERT;
                else if (r < 75)
                    kind = KIND_EXISTS;
                else if (r < 88)
                    kind = KIND_NEXT;
                else
                    kind = KIND_PREV;
                send_request(kind, pick_key());
            end
            if (phase == 2)
                wait_until_idle();
        end
    endtask

    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 2));
            ready_left = $urandom_range(16, 96);
        end
        ready_left--;
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
            default:      m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Result with no request pending: tdata %h", m_tdata);
            end
            else
            begin
                head_result = pending_results.pop_front();
                if (m_tdata[0] !== head_result.found
                    || m_tdata[32:1] !== head_result.answer_key
                    || m_tdata[33] !== head_result.overflow
                    || m_tdata[OUT_DATA_W-1:34] !== '0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"Result %0d: expected found %b key %0d overflow %b, ",
                                  "got found %b key %0d overflow %b pad %b"},
                                 result_count, head_result.found,
                                 $signed(head_result.answer_key), head_result.overflow,
                                 m_tdata[0], $signed(m_tdata[32:1]), m_tdata[33],
                                 m_tdata[OUT_DATA_W-1:34]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("** ordered_key_set: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_and_overflow();
        test_random_mix();
        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d insert, %0d delete, %0d exists, %0d next, %0d prev, %0d unused-kind",
                 kind_count[KIND_INSERT], kind_count[KIND_DELETE], kind_count[KIND_EXISTS],
                 kind_count[KIND_NEXT], kind_count[KIND_PREV],
                 kind_count[KIND_FIRST_UNUSED] + kind_count[KIND_FIRST_UNUSED + 3'd1]
                 + kind_count[KIND_FIRST_UNUSED + 3'd2]);
        $display("Set filled to %0d of %0d, %0d inserts dropped when full, %0d results checked",
                 peak_fill, SET_CAPACITY, overflow_count, result_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("** ordered_key_set: PASSED **");
        else
            $display("** ordered_key_set: FAILED **");
        $finish;
    end

endmodule
